FILE: hdl/mnva_pkg.sv
// package for the midi note voice allocator
// holds the shared types, codes and constants; no dependencies

package mnva_pkg;

    localparam int NUM_VOICES  = 4;
    localparam int VOICE_W     = 2;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = 3;
    localparam int NOTE_W      = 7;
    localparam int CHAN_W      = 4;

    // configuration register indexes
    localparam logic CFG_VOICE_ENABLE   = 1'b0;
    localparam logic CFG_VOICE_CHANNELS = 1'b1;

    localparam logic [NUM_VOICES-1:0]        VOICE_ENABLE_RESET   = 4'h7;
    localparam logic [NUM_VOICES*CHAN_W-1:0] VOICE_CHANNELS_RESET = 16'h0132;

    // status nibbles and special velocity
    localparam logic [3:0]        STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0]        STAT_NOTE_ON  = 4'h9;
    localparam logic [NOTE_W-1:0] VEL_DEFAULT   = 7'h40;

    typedef enum logic [4:0] {
        PS_IDLE     = 5'b00001,
        PS_OFF_NOTE = 5'b00010,
        PS_OFF_VEL  = 5'b00100,
        PS_ON_NOTE  = 5'b01000,
        PS_ON_VEL   = 5'b10000
    } parse_state_t;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [7:0]         status;
        logic [NOTE_W-1:0]  note;
        logic [NOTE_W-1:0]  vel;
        logic               last;
    } msg_t;

    typedef struct packed {
        parse_state_t                        parse;
        logic [NUM_VOICES-1:0]               busy;
        logic [NUM_VOICES-1:0][NOTE_W-1:0]   note;
        logic [VOICE_W-1:0]                  next_voice;
        logic [NOTE_W-1:0]                   held_note;
    } alloc_state_t;

endpackage

FILE: hdl/midi_note_voice_allocator_unit.sv
// Takes a raw MIDI byte stream and routes note-on and note-off messages to
// four voices, round robin. A byte enters the input register, is parsed and
// allocated once the message buffer is free, and its messages (zero to four)
// are loaded into a message buffer that drains through the output port one
// per cycle while out_stall is low. A byte that causes messages holds the
// next byte in the input register until its final message leaves the single
// output port. The input register takes a new byte while a message still
// waits to be taken. Configuration is taken every cycle (cfg_ready is
// always high). Depends on mnva_pkg and mnva_engine.

module midi_note_voice_allocator_unit
    import mnva_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [15:0]                  cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   midi_byte,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [VOICE_W-1:0]           voice,
    output logic [7:0]                   status_byte,
    output logic [NOTE_W-1:0]            note_number,
    output logic [NOTE_W-1:0]            velocity,
    output logic                         last
);

    logic [NUM_VOICES-1:0]           voice_enable_reg;
    logic [NUM_VOICES*CHAN_W-1:0]    voice_channels_reg;

    logic                            in_full_reg;
    logic [7:0]                      in_byte_reg;

    alloc_state_t                    st_reg;
    alloc_state_t                    st_next;

    msg_t [MAX_RESULTS-1:0]          buf_reg;
    msg_t [MAX_RESULTS-1:0]          buf_next;
    logic [CNT_W-1:0]                cnt_reg;
    logic [CNT_W-1:0]                cnt_next;

    msg_t [MAX_RESULTS-1:0]          eng_msgs;
    logic [CNT_W-1:0]                eng_cnt;

    logic                            out_fire;
    logic                            in_fire;
    logic                            drained;
    logic                            process;

    mnva_engine u_engine (
        .midi_byte      (in_byte_reg),
        .voice_enable   (voice_enable_reg),
        .voice_channels (voice_channels_reg),
        .st             (st_reg),
        .st_next        (st_next),
        .msgs           (eng_msgs),
        .msg_cnt        (eng_cnt)
    );

    assign cfg_ready = 1'b1;

    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid & ~out_stall;
    // buffer is free once its final message leaves
    assign drained   = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_fire);
    assign process   = in_full_reg & drained;
    assign in_stall  = in_full_reg & ~process;
    assign in_fire   = in_valid & ~in_stall;

    assign voice       = buf_reg[0].voice;
    assign status_byte = buf_reg[0].status;
    assign note_number = buf_reg[0].note;
    assign velocity    = buf_reg[0].vel;
    assign last        = buf_reg[0].last;

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (process)
        begin
            buf_next = eng_msgs;
            cnt_next = eng_cnt;
        end
        else if (out_fire)
        begin
            for (int k = 0; k < MAX_RESULTS - 1; k++)
                buf_next[k] = buf_reg[k+1];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_enable_reg   <= VOICE_ENABLE_RESET;
            voice_channels_reg <= VOICE_CHANNELS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VOICE_ENABLE:   voice_enable_reg   <= cfg_data[NUM_VOICES-1:0];
                CFG_VOICE_CHANNELS: voice_channels_reg <= cfg_data;
                default:            voice_enable_reg   <= voice_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            cnt_reg       <= '0;
            st_reg.parse      <= PS_IDLE;
            st_reg.busy       <= '0;
            st_reg.note       <= '0;
            st_reg.next_voice <= '0;
            st_reg.held_note  <= '0;
        end
        else
        begin
            if (in_fire)
                in_full_reg <= 1'b1;
            else if (process)
                in_full_reg <= 1'b0;
            cnt_reg <= cnt_next;
            if (process)
                st_reg <= st_next;
        end
    end

    // payload and message buffer carry no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_byte_reg <= midi_byte;
        buf_reg <= buf_next;
    end

endmodule

FILE: hdl/mnva_engine.sv
// per-byte parser and voice allocation logic, purely combinational
// depends on mnva_pkg

module mnva_engine
    import mnva_pkg::*;
(
    input  logic [7:0]                       midi_byte,
    input  logic [NUM_VOICES-1:0]            voice_enable,
    input  logic [NUM_VOICES*CHAN_W-1:0]     voice_channels,
    input  alloc_state_t                     st,
    output alloc_state_t                     st_next,
    output msg_t [MAX_RESULTS-1:0]           msgs,
    output logic [CNT_W-1:0]                 msg_cnt
);

    logic                        is_data;
    logic [NOTE_W-1:0]           data7;

    // release path
    logic                        stop_on_zero;
    logic [NOTE_W-1:0]           stop_vel;
    logic [NUM_VOICES-1:0]       stop_hit;
    msg_t [MAX_RESULTS-1:0]      stop_msgs;
    logic [CNT_W-1:0]            stop_cnt;

    // start path
    logic [NUM_VOICES-1:0]       free_mask;
    logic                        found_free;
    logic                        found_en;
    logic [VOICE_W-1:0]          pick_free;
    logic [VOICE_W-1:0]          pick_en;
    logic [VOICE_W-1:0]          pick;
    logic                        steal;
    msg_t [MAX_RESULTS-1:0]      start_msgs;
    logic [CNT_W-1:0]            start_cnt;

    assign is_data = ~midi_byte[7];
    assign data7   = midi_byte[NOTE_W-1:0];

    // note-off, or note-on with zero velocity
    always_comb
    begin
        logic [CNT_W-1:0] pos;
        stop_on_zero = (st.parse == PS_ON_VEL);
        stop_vel     = stop_on_zero ? VEL_DEFAULT : data7;
        stop_msgs    = '0;
        pos          = '0;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            stop_hit[i] = voice_enable[i] & st.busy[i] & (st.note[i] == st.held_note);
            if (stop_hit[i])
            begin
                stop_msgs[pos[VOICE_W-1:0]].voice = VOICE_W'(i);
                stop_msgs[pos[VOICE_W-1:0]].note  = st.held_note;
                if (stop_vel == VEL_DEFAULT)
                begin
                    stop_msgs[pos[VOICE_W-1:0]].status =
                        {STAT_NOTE_ON, voice_channels[CHAN_W*i +: CHAN_W]};
                    stop_msgs[pos[VOICE_W-1:0]].vel = '0;
                end
                else
                begin
                    stop_msgs[pos[VOICE_W-1:0]].status =
                        {STAT_NOTE_OFF, voice_channels[CHAN_W*i +: CHAN_W]};
                    stop_msgs[pos[VOICE_W-1:0]].vel = stop_vel;
                end
                pos = pos + CNT_W'(1);
            end
        end
        stop_cnt = pos;
    end

    // round-robin search: free enabled voice first, else steal first enabled one
    always_comb
    begin
        logic [VOICE_W-1:0] v;
        free_mask  = voice_enable & ~st.busy;
        found_free = 1'b0;
        found_en   = 1'b0;
        pick_free  = '0;
        pick_en    = '0;
        for (int k = 0; k < NUM_VOICES; k++)
        begin
            v = st.next_voice + VOICE_W'(k);
            if (!found_free && free_mask[v])
            begin
                found_free = 1'b1;
                pick_free  = v;
            end
            if (!found_en && voice_enable[v])
            begin
                found_en = 1'b1;
                pick_en  = v;
            end
        end
        pick  = found_free ? pick_free : pick_en;
        steal = st.busy[pick];

        start_msgs = '0;
        if (steal)
        begin
            start_msgs[0].voice  = pick;
            start_msgs[0].status = {STAT_NOTE_ON, voice_channels[CHAN_W*pick +: CHAN_W]};
            start_msgs[0].note   = st.note[pick];
            start_msgs[0].vel    = '0;
            start_msgs[1].voice  = pick;
            start_msgs[1].status = {STAT_NOTE_ON, voice_channels[CHAN_W*pick +: CHAN_W]};
            start_msgs[1].note   = st.held_note;
            start_msgs[1].vel    = data7;
        end
        else
        begin
            start_msgs[0].voice  = pick;
            start_msgs[0].status = {STAT_NOTE_ON, voice_channels[CHAN_W*pick +: CHAN_W]};
            start_msgs[0].note   = st.held_note;
            start_msgs[0].vel    = data7;
        end
        if (!found_en)
            start_cnt = '0;
        else if (steal)
            start_cnt = CNT_W'(2);
        else
            start_cnt = CNT_W'(1);
    end

    always_comb
    begin
        st_next = st;
        msgs    = '0;
        msg_cnt = '0;
        if (!is_data)
        begin
            // any status byte restarts parsing
            if (midi_byte[7:4] == STAT_NOTE_OFF)
                st_next.parse = PS_OFF_NOTE;
            else if (midi_byte[7:4] == STAT_NOTE_ON)
                st_next.parse = PS_ON_NOTE;
            else
                st_next.parse = PS_IDLE;
        end
        else
        begin
            case (st.parse)
                PS_OFF_NOTE:
                begin
                    st_next.held_note = data7;
                    st_next.parse     = PS_OFF_VEL;
                end
                PS_OFF_VEL:
                begin
                    msgs          = stop_msgs;
                    msg_cnt       = stop_cnt;
                    st_next.busy  = st.busy & ~stop_hit;
                    st_next.parse = PS_OFF_NOTE;
                end
                PS_ON_NOTE:
                begin
                    st_next.held_note = data7;
                    st_next.parse     = PS_ON_VEL;
                end
                PS_ON_VEL:
                begin
                    if (data7 == '0)
                    begin
                        msgs         = stop_msgs;
                        msg_cnt      = stop_cnt;
                        st_next.busy = st.busy & ~stop_hit;
                    end
                    else
                    begin
                        msgs    = start_msgs;
                        msg_cnt = start_cnt;
                        if (found_en)
                        begin
                            st_next.busy[pick] = 1'b1;
                            st_next.note[pick] = st.held_note;
                            st_next.next_voice = pick + VOICE_W'(1);
                        end
                    end
                    st_next.parse = PS_ON_NOTE;
                end
                default:
                    st_next.parse = PS_IDLE;
            endcase
        end
        for (int k = 0; k < MAX_RESULTS; k++)
            msgs[k].last = (CNT_W'(k + 1) == msg_cnt);
    end

endmodule

FILE: hdl/mnva_checker.sv
// port-level checks for the midi note voice allocator, bound to the top level
// depends on midi_note_voice_allocator_unit port names

module mnva_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] voice,
    input logic [7:0] status_byte,
    input logic [6:0] note_number,
    input logic [6:0] velocity,
    input logic       last
);

    // a stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({voice, status_byte,
                                   note_number, velocity, last}))
        else $error("output transaction changed while stalled");

    // only note-on or note-off status leaves the block
    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status_byte[7:5] == 3'b100)
        else $error("status byte is not note-on or note-off");

    // default release velocity always goes out as note-on with zero velocity
    a_off_vel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status_byte[4] |-> velocity != 7'h40)
        else $error("note-off sent with default velocity");

    // a byte's messages go out without a gap
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("message burst broken before its last transaction");

endmodule

bind midi_note_voice_allocator_unit mnva_checker u_mnva_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .voice       (voice),
    .status_byte (status_byte),
    .note_number (note_number),
    .velocity    (velocity),
    .last        (last)
);
